/* rtl/core/ntclf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC lookup filter package
// Shared widths, fault codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ntclf_pkg;

    localparam int CODE_W  = 10;
    localparam int TEMP_W  = 8;
    localparam int FAULT_W = 2;
    localparam int TIDX_W  = 8;

    localparam int SEARCH_START = 50;

    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_BELOW = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ABOVE = 2'd2;

    // retry counter wraps past this, fault cycle counter saturates here
    localparam logic [1:0] RETRY_LIMIT = 2'd1;
    localparam logic [1:0] FAULT_SAT   = 2'd2;

    typedef enum logic [1:0] {
        ADDR_END,
        ADDR_ZERO,
        ADDR_SEARCH
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t           addr_sel;
        logic                tbl_wr;
        logic                latch_in;
        logic                set_fault;
        logic [FAULT_W-1:0]  fault_val;
        logic                search_init;
        logic                search_step;
        logic                update;
    } cmd_t;

    typedef struct packed {
        logic below_end;
        logic above_start;
        logic search_done;
    } sts_t;

endpackage

/* rtl/core/ntclf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC lookup filter controller
// Sequences range checks, bisection reads and the filter update per sample.
// ----------------------------------------------------------------------------
module ntclf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tuser,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output ntclf_pkg::cmd_t cmd,
    input  ntclf_pkg::sts_t sts
);
    import ntclf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_END,
        ST_CHK_START,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.addr_sel  = ADDR_END;
        cmd.fault_val = FAULT_NONE;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.tbl_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_in = 1'b1;
                        state_next   = ST_CHK_END;
                    end
                end
            end
            ST_CHK_END:
            begin
                cmd.addr_sel  = ADDR_ZERO;
                cmd.set_fault = 1'b1;
                cmd.fault_val = sts.below_end ? FAULT_BELOW : FAULT_NONE;
                state_next    = sts.below_end ? ST_UPDATE : ST_CHK_START;
            end
            ST_CHK_START:
            begin
                cmd.addr_sel    = ADDR_SEARCH;
                cmd.search_init = 1'b1;
                cmd.set_fault   = sts.above_start;
                cmd.fault_val   = FAULT_ABOVE;
                state_next      = sts.above_start ? ST_UPDATE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.addr_sel = ADDR_SEARCH;
                if (sts.search_done)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.update    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* rtl/core/ntclf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC lookup filter datapath
// Code table memory, bisection registers, fault counters and output filter.
// ----------------------------------------------------------------------------
module ntclf_dp #(
    parameter int TABLE_DEPTH = 141,
    parameter int TEMP_OFFSET = 20
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ntclf_pkg::cmd_t                    cmd,
    output ntclf_pkg::sts_t                    sts,
    input  logic [ntclf_pkg::CODE_W-1:0]       adc_code,
    input  logic [ntclf_pkg::TIDX_W-1:0]       table_index,
    output logic signed [ntclf_pkg::TEMP_W-1:0] temperature,
    output logic [ntclf_pkg::FAULT_W-1:0]      fault
);
    import ntclf_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int START_INT = (SEARCH_START < TABLE_DEPTH - 1) ? SEARCH_START
                                                               : TABLE_DEPTH - 1;
    localparam int FBELOW_INT = (TABLE_DEPTH - 1 - TEMP_OFFSET > 127) ? 127
                                                                    : TABLE_DEPTH - 1 - TEMP_OFFSET;
    localparam logic [IDX_W-1:0]        LAST_IDX    = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0]        START_IDX   = IDX_W'(START_INT);
    localparam logic [TIDX_W:0]         DEPTH_LIM   = (TIDX_W + 1)'(TABLE_DEPTH);
    localparam logic signed [TEMP_W-1:0] FORCE_BELOW = TEMP_W'(FBELOW_INT);
    localparam logic signed [TEMP_W-1:0] FORCE_ABOVE = TEMP_W'(-TEMP_OFFSET);
    localparam logic signed [9:0]       OFFSET_10   = 10'(TEMP_OFFSET);

    // table memory, one write and one registered read per cycle
    logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_ok;

    logic [CODE_W-1:0]  code_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   low_reg, low_next;
    logic [IDX_W-1:0]   high_reg, high_next;
    logic [IDX_W:0]     mid_sum;
    logic               code_lt, code_eq, keep_going;

    logic signed [TEMP_W-1:0] held_reg, held_next;
    logic signed [TEMP_W-1:0] last_reg, last_next;
    logic [1:0]               filt_cnt_reg, filt_cnt_next;
    logic [1:0]               retry_reg, retry_next;
    logic [1:0]               fcyc_reg, fcyc_next;

    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [FAULT_W-1:0]       out_fault_reg;

    logic signed [9:0]        t_diff;
    logic signed [TEMP_W-1:0] t_raw, last_eff, held_eff, avg;
    logic signed [TEMP_W:0]   sum9, avg9;
    logic [1:0]               fc_inc, retry_inc;
    logic                     retry_wrap;

    assign wr_ok = ({1'b0, table_index} < DEPTH_LIM);

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr && wr_ok)
        begin
            code_mem[table_index[IDX_W-1:0]] <= adc_code;
        end
        rd_data_reg <= code_mem[rd_addr];
    end

    // bisection step
    assign code_lt    = (code_reg < rd_data_reg);
    assign code_eq    = (code_reg == rd_data_reg);
    assign keep_going = ({1'b0, high_reg} > ({1'b0, low_reg} + (IDX_W + 1)'(2)));

    assign sts.below_end   = code_lt;
    assign sts.above_start = (code_reg > rd_data_reg);
    assign sts.search_done = !keep_going || code_eq;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        idx_next  = idx_reg;
        mid_sum   = '0;
        if (cmd.search_init)
        begin
            low_next  = '0;
            high_next = LAST_IDX;
            idx_next  = START_IDX;
        end
        else if (cmd.search_step)
        begin
            low_next  = code_lt ? idx_reg : low_reg;
            high_next = code_lt ? high_reg : idx_reg;
            mid_sum   = {1'b0, low_next} + {1'b0, high_next};
            idx_next  = mid_sum[IDX_W:1];
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_END:    rd_addr = LAST_IDX;
            ADDR_ZERO:   rd_addr = '0;
            ADDR_SEARCH: rd_addr = idx_next;
            default:     rd_addr = LAST_IDX;
        endcase
    end

    // temperature from located index, filter and fault counters
    assign t_diff = signed'(10'(idx_reg)) - OFFSET_10;
    assign t_raw  = (t_diff > 10'sd127) ? 8'sd127 : t_diff[TEMP_W-1:0];

    always_comb
    begin
        last_eff   = (last_reg == '0) ? t_raw : last_reg;
        held_eff   = (last_reg == '0) ? t_raw : held_reg;
        fc_inc     = filt_cnt_reg + 2'd1;
        sum9       = {t_raw[TEMP_W-1], t_raw} + {last_eff[TEMP_W-1], last_eff};
        // halve, rounding toward zero
        avg9       = (sum9 + {{TEMP_W{1'b0}}, sum9[TEMP_W]}) >>> 1;
        avg        = avg9[TEMP_W-1:0];
        retry_inc  = retry_reg + 2'd1;
        retry_wrap = (retry_inc > RETRY_LIMIT);

        held_next     = held_reg;
        last_next     = last_reg;
        filt_cnt_next = filt_cnt_reg;
        retry_next    = retry_reg;
        fcyc_next     = fcyc_reg;

        if (fault_reg != FAULT_NONE)
        begin
            retry_next = retry_wrap ? 2'd0 : retry_inc;
            fcyc_next  = (retry_wrap && (fcyc_reg < FAULT_SAT)) ? fcyc_reg + 2'd1 : fcyc_reg;
            if (fcyc_next >= FAULT_SAT)
            begin
                held_next = (fault_reg == FAULT_BELOW) ? FORCE_BELOW : FORCE_ABOVE;
            end
        end
        else
        begin
            retry_next = '0;
            fcyc_next  = '0;
            if (fc_inc > 2'd2)
            begin
                held_next     = avg;
                last_next     = last_eff;
                filt_cnt_next = '0;
            end
            else
            begin
                held_next     = held_eff;
                last_next     = avg;
                filt_cnt_next = fc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            last_reg     <= '0;
            filt_cnt_reg <= '0;
            retry_reg    <= '0;
            fcyc_reg     <= '0;
        end
        else if (cmd.update)
        begin
            held_reg     <= held_next;
            last_reg     <= last_next;
            filt_cnt_reg <= filt_cnt_next;
            retry_reg    <= retry_next;
            fcyc_reg     <= fcyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            code_reg <= adc_code;
        end
        if (cmd.set_fault)
        begin
            fault_reg <= cmd.fault_val;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
        idx_reg  <= idx_next;
        if (cmd.update)
        begin
            out_temp_reg  <= held_next;
            out_fault_reg <= fault_reg;
        end
    end

    assign temperature = out_temp_reg;
    assign fault       = out_fault_reg;

endmodule

/* rtl/core/ntc_temperature_lookup_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC temperature lookup filter
// Thermistor code to degrees Celsius by table bisection, with fault hold.
// ----------------------------------------------------------------------------
// Transactions with tuser = 1 load one entry of the descending code table and
// give no result. A converter sample (tuser = 0) gives one result: it is
// accepted, checked against the last and then the first table entry, located
// by bisection steps until the search ends, and then written by the update,
// which waits for the result register to empty. A code below the table end or
// above the table start skips the search and goes straight to the update.
// The single read port of the table memory sets the step rate. The table must
// be loaded before samples are sent. A new transaction is taken while the
// previous result waits in the output register.
module ntc_temperature_lookup_filter #(
    parameter int TABLE_DEPTH = 141,
    parameter int TEMP_OFFSET = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // adc_code[9:0], table_index[17:10], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // temperature[7:0], fault[9:8], zero pad
);
    import ntclf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic signed [TEMP_W-1:0] temperature;
    logic [FAULT_W-1:0]       fault;

    ntclf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ntclf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TEMP_OFFSET (TEMP_OFFSET)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .adc_code    (s_tdata[9:0]),
        .table_index (s_tdata[17:10]),
        .temperature (temperature),
        .fault       (fault)
    );

    assign m_tdata = {6'b0, fault, temperature};

    // result register is only loaded when it is empty or being drained
    a_update_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    // a sample keeps the block busy for at least the range checks
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> (!s_tready ##1 !s_tready))
        else $error("sample finished too early");

    // a table load leaves the block ready and gives no result
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (s_tready && !$rose(m_tvalid)))
        else $error("table load disturbed the sequencer");

endmodule

/* verif/ntc_temperature_lookup_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC lookup filter checker
// Watches both stream channels, tracks the table, fault counters and pairwise
// filter on every accepted sample, and compares each reading with the oldest
// expected one.
// ----------------------------------------------------------------------------
package ntclf_tb_pkg;

    typedef enum logic {
        REQ_SAMPLE,
        REQ_TABLE_WR
    } req_kind_t;

endpackage

module ntc_temperature_lookup_filter_checker
    import ntclf_pkg::*;
    import ntclf_tb_pkg::*;
#(
    parameter int TABLE_DEPTH = 141,
    parameter int TEMP_OFFSET = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // adc_code[9:0], table_index[17:10], zero pad
    input  logic        s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // temperature[7:0], fault[9:8], zero pad
    output int          mismatches,
    output int          pending,
    output int          readings_seen
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [FAULT_W-1:0]       fault;
    } reading_t;

    reading_t expected_readings[$];

    logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
    int                held_temp;
    int                last_temp;
    logic [1:0]        filter_cnt;
    logic [1:0]        retry_cnt;
    logic [1:0]        fault_cyc;

    function automatic int sat_temp(input int v);
        if (v > 127)
        begin
            return 127;
        end
        if (v < -128)
        begin
            return -128;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_and_compare
        reading_t          want;
        reading_t          got;
        logic [CODE_W-1:0] code;
        logic [TIDX_W-1:0] widx;
        logic              below;
        int                forced;
        int                lo;
        int                hi;
        int                idx;
        int                t;
        int                avg;
        int                errs;

        if (!rst_n)
        begin
            expected_readings.delete();
            held_temp     = 0;
            last_temp     = 0;
            filter_cnt    = '0;
            retry_cnt     = '0;
            fault_cyc     = '0;
            mismatches    <= 0;
            pending       <= 0;
            readings_seen <= 0;
        end
        else
        begin
            errs = 0;
            // result side first: a reading leaving now belongs to an earlier sample
            if (m_tvalid && m_tready)
            begin
                got.temp  = m_tdata[7:0];
                got.fault = m_tdata[9:8];
                readings_seen <= readings_seen + 1;
                if (expected_readings.size() == 0)
                begin
                    $error("reading with none expected: temperature %0d fault %0d",
                           $signed(got.temp), got.fault);
                    errs++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.temp !== want.temp)
                    begin
                        $error("temperature: expected %0d, got %0d",
                               $signed(want.temp), $signed(got.temp));
                        errs++;
                    end
                    if (got.fault !== want.fault)
                    begin
                        $error("fault: expected %0d, got %0d", want.fault, got.fault);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;

            if (s_tvalid && s_tready)
            begin
                code = s_tdata[9:0];
                widx = s_tdata[17:10];
                if (s_tuser == REQ_TABLE_WR)
                begin
                    if (widx < TABLE_DEPTH)
                    begin
                        code_tbl[widx] = code;
                    end
                end
                else if (code < code_tbl[TABLE_DEPTH-1] || code > code_tbl[0])
                begin
                    below  = code < code_tbl[TABLE_DEPTH-1];
                    forced = below ? (TABLE_DEPTH - 1 - TEMP_OFFSET) : -TEMP_OFFSET;
                    retry_cnt = retry_cnt + 2'd1;
                    if (retry_cnt > RETRY_LIMIT)
                    begin
                        retry_cnt = '0;
                        if (fault_cyc < FAULT_SAT)
                        begin
                            fault_cyc = fault_cyc + 2'd1;
                        end
                    end
                    if (fault_cyc >= FAULT_SAT)
                    begin
                        held_temp = sat_temp(forced);
                    end
                    want.temp  = held_temp[7:0];
                    want.fault = below ? FAULT_BELOW : FAULT_ABOVE;
                    expected_readings.push_back(want);
                end
                else
                begin
                    retry_cnt = '0;
                    fault_cyc = '0;
                    lo  = 0;
                    hi  = TABLE_DEPTH - 1;
                    idx = (SEARCH_START < TABLE_DEPTH - 1) ? SEARCH_START : TABLE_DEPTH - 1;
                    while (hi > lo + 2)
                    begin
                        if (code < code_tbl[idx])
                        begin
                            lo = idx;
                        end
                        else if (code == code_tbl[idx])
                        begin
                            break;
                        end
                        else
                        begin
                            hi = idx;
                        end
                        idx = (hi + lo) / 2;
                    end
                    t = sat_temp(idx - TEMP_OFFSET);
                    // an empty history (or a real 0 degC one) reseeds the filter
                    if (last_temp == 0)
                    begin
                        last_temp = t;
                        held_temp = t;
                    end
                    filter_cnt = filter_cnt + 2'd1;
                    avg = (t + last_temp) / 2;
                    if (filter_cnt > 2'd2)
                    begin
                        held_temp  = avg;
                        filter_cnt = '0;
                    end
                    else
                    begin
                        last_temp = avg;
                    end
                    want.temp  = held_temp[7:0];
                    want.fault = FAULT_NONE;
                    expected_readings.push_back(want);
                end
            end

            pending <= expected_readings.size();
        end
    end

endmodule

/* verif/ntc_temperature_lookup_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC lookup filter testbench
// Loads descending code tables, then drives directed and random converter
// samples (valid, exact-match, out-of-table runs) with random gaps on both
// channels; the checker module does the comparison.
// ----------------------------------------------------------------------------
module ntc_temperature_lookup_filter_tb;

    import ntclf_pkg::*;
    import ntclf_tb_pkg::*;

    localparam int TABLE_DEPTH = 141;
    localparam int TEMP_OFFSET = 20;
    localparam int ITEM_GOAL   = 2000;
    localparam int IDLE_LIMIT  = 3000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int mismatches;
    int pending;
    int readings_seen;

    logic [CODE_W-1:0] shadow_tbl [TABLE_DEPTH];
    bit                gapless   = 1'b0;
    int                n_samples = 0;
    int                n_faulty  = 0;
    int                n_loads   = 0;
    int                idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ntc_temperature_lookup_filter #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TEMP_OFFSET (TEMP_OFFSET)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ntc_temperature_lookup_filter_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TEMP_OFFSET (TEMP_OFFSET)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .readings_seen (readings_seen)
    );

    always @(posedge clk)
    begin
        m_tready <= gapless || ($urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[ntc_temperature_lookup_filter] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one transaction; returns at the edge where it is taken
    task automatic send_item(input req_kind_t kind, input logic [9:0] code,
                             input logic [7:0] idx);
        while (!gapless && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, idx, code};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (kind == REQ_TABLE_WR)
        begin
            if (idx < TABLE_DEPTH)
            begin
                shadow_tbl[idx] = code;
            end
        end
        else
        begin
            n_samples++;
        end
    endtask

    task automatic load_table(input int hi, input int lo);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_item(REQ_TABLE_WR, 10'(hi - ((hi - lo) * i) / (TABLE_DEPTH - 1)), 8'(i));
        end
        n_loads++;
    endtask

    initial
    begin : stimulus
        int               n_items;
        int               next_reload;
        int               pick;
        int               run;
        int               hi;
        int               lo;
        bit               go_below;
        logic [7:0]       idx;
        logic [CODE_W-1:0] code;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: entry i holds 1000 - 7*i, so index 20 (0 degC) is 860
        load_table(1000, 20);
        send_item(REQ_SAMPLE, 10'd860, 8'd0);    // reseed from empty history at 0 degC
        send_item(REQ_SAMPLE, 10'd860, 8'd0);
        send_item(REQ_SAMPLE, 10'd650, 8'd0);    // exact hit on the first probe
        send_item(REQ_SAMPLE, 10'd1000, 8'd0);   // table start
        send_item(REQ_SAMPLE, 10'd20, 8'd0);     // table end
        send_item(REQ_SAMPLE, 10'd861, 8'd0);    // between entries
        repeat (5) send_item(REQ_SAMPLE, 10'd1023, 8'd0);   // above start until forced
        send_item(REQ_SAMPLE, 10'd500, 8'd0);    // valid code clears counters
        repeat (5) send_item(REQ_SAMPLE, 10'd0, 8'd0);      // below end until forced
        send_item(REQ_SAMPLE, 10'd333, 8'd0);
        send_item(REQ_TABLE_WR, 10'd1023, 8'd255);          // ignored, index out of range
        send_item(REQ_TABLE_WR, 10'd0, 8'd141);             // ignored
        send_item(REQ_TABLE_WR, 10'd0, 8'd140);
        send_item(REQ_SAMPLE, 10'd0, 8'd0);      // now the bottom entry itself
        send_item(REQ_SAMPLE, 10'd1, 8'd0);

        // n_items counts every transaction, table loads included
        n_items     = 0;
        next_reload = 0;
        while (n_items < ITEM_GOAL)
        begin
            gapless = (n_items >= 900) && (n_items < 1200);
            if (n_items >= next_reload)
            begin
                hi = ($urandom_range(3) == 0) ? 1023 : $urandom_range(1022, 600);
                lo = ($urandom_range(3) == 0) ? 0 : $urandom_range(300, 1);
                // narrow tables give flat runs of equal codes
                if ($urandom_range(4) == 0)
                begin
                    lo = hi - $urandom_range(139, 20);
                end
                load_table(hi, lo);
                n_items     += TABLE_DEPTH;
                next_reload = n_items + $urandom_range(500, 250);
            end
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                // stray write, may break the ordering until the next reload
                idx = 8'($urandom_range(255));
                send_item(REQ_TABLE_WR, 10'($urandom_range(1023)), idx);
                n_items++;
            end
            else if (pick < 20)
            begin
                run      = $urandom_range(6, 1);
                go_below = 1'($urandom_range(1));
                repeat (run)
                begin
                    if (go_below && shadow_tbl[TABLE_DEPTH-1] > 0)
                    begin
                        code = 10'($urandom_range(shadow_tbl[TABLE_DEPTH-1] - 1, 0));
                    end
                    else if (shadow_tbl[0] < 10'd1023)
                    begin
                        code = 10'($urandom_range(1023, shadow_tbl[0] + 1));
                    end
                    else
                    begin
                        code = 10'($urandom_range(1023));
                    end
                    send_item(REQ_SAMPLE, code, 8'($urandom_range(255)));
                    n_items++;
                    n_faulty++;
                end
            end
            else
            begin
                run = $urandom_range(8, 1);
                repeat (run)
                begin
                    if ($urandom_range(9) < 4)
                    begin
                        code = shadow_tbl[8'($urandom_range(TABLE_DEPTH - 1))];
                    end
                    else
                    begin
                        code = 10'($urandom_range(shadow_tbl[0], shadow_tbl[TABLE_DEPTH-1]));
                    end
                    send_item(REQ_SAMPLE, code, 8'($urandom_range(255)));
                    n_items++;
                end
            end
        end
        s_tvalid <= 1'b0;
        gapless  = 1'b0;

        // let the checker register the last sample before looking at pending
        repeat (2) @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Run covered %0d samples (%0d aimed outside the table) over %0d table loads,",
                 n_samples, n_faulty, n_loads);
        $display("with %0d readings compared against the prediction.", readings_seen);
        if (mismatches == 0)
        begin
            $display("[ntc_temperature_lookup_filter] OK");
        end
        else
        begin
            $display("[ntc_temperature_lookup_filter] ERROR");
        end
        $finish;
    end

endmodule
